/* sv/blsi_pkg.sv */
package blsi_pkg;

  localparam int unsigned DATA_W = 32;

  // request codes
  localparam logic [2:0] REQ_INS_HEAD   = 3'd0;
  localparam logic [2:0] REQ_INS_TAIL   = 3'd1;
  localparam logic [2:0] REQ_REM_HEAD   = 3'd2;
  localparam logic [2:0] REQ_REM_TAIL   = 3'd3;
  localparam logic [2:0] REQ_INS_SORTED = 3'd4;
  localparam logic [2:0] REQ_DUMP       = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

/* sv/blsi_ram.sv */
module blsi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/bounded_list_deque_sorted_insert_unit.sv */
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+----------------------------
// request   | req_type_i, value_in_i                    | taken when start && !busy
// result    | status_o, value_out_o, last_o             | done_o high for one cycle
//
// entries sit in a ram with one write and one registered read port, so every moved
// or read entry takes a read state, then a write or emit state; beats are registered.
// remove tail, refused, empty and spare requests are answered from idle; insert tail puts;
// insert head shifts every entry up, remove head shifts them down, dump emits each;
// sorted insert scans to the first greater entry, shifts the tail up to it and puts.
// reset clears state, count and done_o, no ram clearing pass; the receiver cannot stall.
module bounded_list_deque_sorted_insert_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] value_in_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] value_out_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_UP_RD    = 4'd3;
  localparam logic [3:0] S_UP_WR    = 4'd4;
  localparam logic [3:0] S_PUT      = 4'd5;
  localparam logic [3:0] S_DN_RD    = 4'd6;
  localparam logic [3:0] S_DN_WR    = 4'd7;
  localparam logic [3:0] S_DUMP_RD  = 4'd8;
  localparam logic [3:0] S_DUMP_OUT = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pos_q, pos_d;
  logic signed [blsi_pkg::DATA_W-1:0] val_q, val_d;

  logic               res_valid_q, res_valid_d;
  logic [1:0]         res_status_q, res_status_d;
  logic signed [31:0] res_value_q, res_value_d;
  logic               res_last_q, res_last_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [blsi_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [blsi_pkg::DATA_W-1:0] ram_rdata;

  logic          accept;
  logic          full;
  logic          step_dn;
  logic [CW-1:0] adj;
  logic [CW-1:0] cnt_m1;
  logic          greater;

  blsi_ram #(
    .WIDTH (blsi_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (cnt_q == CW'(DEPTH));
  assign cnt_m1  = cnt_q - CW'(1);

  // shared index stepper and the scan comparator
  assign step_dn = (state_q == S_UP_RD) || (state_q == S_UP_WR);
  assign adj     = CW'(idx_q) + (step_dn ? {CW{1'b1}} : CW'(1));
  assign greater = $signed(ram_rdata) > val_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    val_d        = val_q;
    res_valid_d  = 1'b0;
    res_status_d = blsi_pkg::ST_OK;
    res_value_d  = '0;
    res_last_d   = 1'b1;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = value_in_i;
          priority if ((req_type_i == blsi_pkg::REQ_INS_HEAD) ||
                       (req_type_i == blsi_pkg::REQ_INS_TAIL) ||
                       (req_type_i == blsi_pkg::REQ_INS_SORTED)) begin
            if (full) begin
              res_valid_d  = 1'b1;
              res_status_d = blsi_pkg::ST_FULL;
            end else if (req_type_i == blsi_pkg::REQ_INS_TAIL) begin
              pos_d   = cnt_q[AW-1:0];
              state_d = S_PUT;
            end else if (cnt_q == '0) begin
              pos_d   = '0;
              state_d = S_PUT;
            end else if (req_type_i == blsi_pkg::REQ_INS_HEAD) begin
              pos_d   = '0;
              idx_d   = cnt_q[AW-1:0];
              state_d = S_UP_RD;
            end else begin
              idx_d   = '0;
              state_d = S_SCAN_RD;
            end
          end else if ((req_type_i == blsi_pkg::REQ_REM_HEAD) ||
                       (req_type_i == blsi_pkg::REQ_REM_TAIL)) begin
            if (cnt_q == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = blsi_pkg::ST_EMPTY;
            end else if ((req_type_i == blsi_pkg::REQ_REM_TAIL) ||
                         (cnt_q == CW'(1))) begin
              cnt_d       = cnt_m1;
              res_valid_d = 1'b1;
            end else begin
              idx_d   = '0;
              state_d = S_DN_RD;
            end
          end else if (req_type_i == blsi_pkg::REQ_DUMP) begin
            if (cnt_q == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = blsi_pkg::ST_EMPTY;
            end else begin
              idx_d   = '0;
              state_d = S_DUMP_RD;
            end
          end else begin
            res_valid_d = 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (greater) begin
          pos_d   = idx_q;
          idx_d   = cnt_q[AW-1:0];
          state_d = S_UP_RD;
        end else if (adj == cnt_q) begin
          pos_d   = cnt_q[AW-1:0];
          state_d = S_PUT;
        end else begin
          idx_d   = adj[AW-1:0];
          state_d = S_SCAN_RD;
        end
      end
      S_UP_RD: begin
        ram_raddr = adj[AW-1:0];
        state_d   = S_UP_WR;
      end
      S_UP_WR: begin
        ram_we = 1'b1;
        idx_d  = adj[AW-1:0];
        if (adj[AW-1:0] == pos_q) begin
          state_d = S_PUT;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = pos_q;
        ram_wdata   = val_q;
        cnt_d       = cnt_q + CW'(1);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_DN_RD: begin
        ram_raddr = adj[AW-1:0];
        state_d   = S_DN_WR;
      end
      S_DN_WR: begin
        ram_we = 1'b1;
        idx_d  = adj[AW-1:0];
        if (adj == cnt_m1) begin
          cnt_d       = cnt_m1;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_DN_RD;
        end
      end
      S_DUMP_RD: begin
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        res_valid_d = 1'b1;
        res_value_d = ram_rdata;
        res_last_d  = (CW'(idx_q) == cnt_m1);
        if (CW'(idx_q) == cnt_m1) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = adj[AW-1:0];
          state_d = S_DUMP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_last_q   <= res_last_d;
  end

  assign done_o      = res_valid_q;
  assign status_o    = res_status_q;
  assign value_out_o = res_value_q;
  assign last_o      = res_last_q;

  // a beat that is not the last of its request only comes from a dump in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy && (status_o == blsi_pkg::ST_OK))
    else $error("non-final beat outside a running dump");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy)
    else $error("ram written while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && ((req_type_i == blsi_pkg::REQ_INS_HEAD) ||
                       (req_type_i == blsi_pkg::REQ_INS_TAIL) ||
                       (req_type_i == blsi_pkg::REQ_INS_SORTED))
    |=> done_o && (status_o == blsi_pkg::ST_FULL) && $stable(cnt_q))
    else $error("insert into full list not refused");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && last_o |-> !busy)
    else $error("final beat while sequencer still running");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned RANDOM_ITEMS = 440;

  // codes the block treats as no-ops
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               last;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] entries [DEPTH];
    int unsigned        count;
    list_result_t       pending [$];
    int unsigned        errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function void push_result(logic [1:0] st, logic signed [31:0] val, logic lst);
      list_result_t r;
      r.status = st;
      r.value  = val;
      r.last   = lst;
      pending.push_back(r);
    endfunction

    // update the list image and queue the beats this request will cause
    function void note_request(logic [2:0] op, logic signed [31:0] val);
      int unsigned pos;
      case (op)
        blsi_pkg::REQ_INS_HEAD, blsi_pkg::REQ_INS_TAIL, blsi_pkg::REQ_INS_SORTED: begin
          if (count >= DEPTH) begin
            push_result(blsi_pkg::ST_FULL, '0, 1'b1);
          end else begin
            pos = (op == blsi_pkg::REQ_INS_HEAD) ? 0 : count;
            if (op == blsi_pkg::REQ_INS_SORTED) begin
              // first entry strictly greater, so equal values keep arrival order
              for (int unsigned i = 0; i < count; i++) begin
                if (entries[i] > val) begin
                  pos = i;
                  break;
                end
              end
            end
            for (int unsigned i = count; i > pos; i--) entries[i] = entries[i - 1];
            entries[pos] = val;
            count++;
            push_result(blsi_pkg::ST_OK, '0, 1'b1);
          end
        end
        blsi_pkg::REQ_REM_HEAD: begin
          if (count == 0) begin
            push_result(blsi_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
            push_result(blsi_pkg::ST_OK, '0, 1'b1);
          end
        end
        blsi_pkg::REQ_REM_TAIL: begin
          if (count == 0) begin
            push_result(blsi_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            count--;
            push_result(blsi_pkg::ST_OK, '0, 1'b1);
          end
        end
        blsi_pkg::REQ_DUMP: begin
          if (count == 0) begin
            push_result(blsi_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < count; i++)
              push_result(blsi_pkg::ST_OK, entries[i], (i + 1 == count));
          end
        end
        default: begin
          push_result(blsi_pkg::ST_OK, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(logic [1:0] st, logic signed [31:0] val, logic lst);
      list_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result beat: status %0d value %0d last %0b", st, val, lst);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        errors++;
      end
      if (val !== exp_r.value) begin
        $error("value_out: expected %0d, got %0d", exp_r.value, val);
        errors++;
      end
      if (lst !== exp_r.last) begin
        $error("last: expected %0b, got %0b", exp_r.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [2:0]         req_type_i;
  logic signed [31:0] value_in_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] value_out_o;
  logic               last_o;

  list_scoreboard sb;
  int unsigned    burst_left;
  int unsigned    idle_cycles;

  bounded_list_deque_sorted_insert_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_type_i (req_type_i),
    .value_in_i (value_in_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .value_out_o(value_out_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = '0;
    value_in_i = '0;
  end

  always #5 clk_i = ~clk_i;

  // results cannot be held off, so every strobed beat is taken at the edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, value_out_o, last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bounded_list_deque_sorted_insert_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high when the next request follows without a gap
  task automatic issue_request(input logic [2:0] op, input logic signed [31:0] val);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= op;
    value_in_i <= val;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_request(op, val);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom;
    if (sel < 70) return $signed($urandom_range(0, 15)) - 8;
    if (sel < 85) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    // reuse a stored value to make ties
    if (sb.count > 0) return sb.entries[$urandom_range(0, sb.count - 1)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(bit filling);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return ($urandom_range(0, 1) != 0) ? REQ_SPARE_6 : REQ_SPARE_7;
    if (sel < 15) return blsi_pkg::REQ_DUMP;
    if (filling ? (sel < 30) : (sel < 75))
      return ($urandom_range(0, 1) != 0) ? blsi_pkg::REQ_REM_HEAD : blsi_pkg::REQ_REM_TAIL;
    case ($urandom_range(0, 3))
      0: return blsi_pkg::REQ_INS_HEAD;
      1: return blsi_pkg::REQ_INS_TAIL;
      default: return blsi_pkg::REQ_INS_SORTED;
    endcase
  endfunction

  initial begin
    bit filling;
    sb = new();
    burst_left = 0;
    filling = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, spare codes
    issue_request(blsi_pkg::REQ_DUMP, 0);
    issue_request(blsi_pkg::REQ_REM_HEAD, 32'sh5a5a_5a5a);
    issue_request(blsi_pkg::REQ_REM_TAIL, -1);
    issue_request(REQ_SPARE_6, VAL_MAX);
    issue_request(REQ_SPARE_7, VAL_MIN);
    // extremes and ties in the sorted path
    issue_request(blsi_pkg::REQ_INS_HEAD, VAL_MIN);
    issue_request(blsi_pkg::REQ_INS_TAIL, VAL_MAX);
    issue_request(blsi_pkg::REQ_INS_SORTED, 0);
    issue_request(blsi_pkg::REQ_INS_SORTED, 0);
    issue_request(blsi_pkg::REQ_INS_SORTED, -1);
    issue_request(blsi_pkg::REQ_INS_SORTED, VAL_MAX);
    issue_request(blsi_pkg::REQ_INS_SORTED, VAL_MIN);
    issue_request(blsi_pkg::REQ_DUMP, 0);
    while (sb.count < DEPTH) issue_request(blsi_pkg::REQ_INS_SORTED, pick_value());
    // full list refuses every insert kind
    issue_request(blsi_pkg::REQ_INS_HEAD, 1);
    issue_request(blsi_pkg::REQ_INS_TAIL, 2);
    issue_request(blsi_pkg::REQ_INS_SORTED, 3);
    issue_request(blsi_pkg::REQ_DUMP, 0);
    issue_request(blsi_pkg::REQ_REM_HEAD, 0);
    issue_request(blsi_pkg::REQ_REM_TAIL, 0);

    // alternate fill and drain phases so full and empty both come up often
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (sb.count == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (sb.count == 0) filling = 1'b1;
      issue_request(pick_op(filling), pick_value());
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bounded_list_deque_sorted_insert_unit regression: pass");
    end else begin
      $display("bounded_list_deque_sorted_insert_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/blsi_pkg.sv
sv/blsi_ram.sv
sv/bounded_list_deque_sorted_insert_unit.sv
dv/testbench.sv
